/* sv/apa_pkg.sv */
// shared types, constants and helpers of the average precision accumulator
package apa_pkg;

  localparam int COUNT_WIDTH = 16;
  localparam int FRAC_BITS   = 16;
  localparam int CFG_W       = 16;

  localparam int NP_W   = (COUNT_WIDTH < CFG_W) ? COUNT_WIDTH : CFG_W;
  localparam int DEN_W  = COUNT_WIDTH + 1;
  localparam int AREA_W = FRAC_BITS + 1;
  localparam int PREV_W = FRAC_BITS + 2;
  localparam int PROD_W = AREA_W + PREV_W;
  localparam int SUM_W  = PROD_W - FRAC_BITS + 1;
  localparam int CNT_W  = $clog2(FRAC_BITS + 1);

  localparam logic [AREA_W-1:0] Q_ONE   = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [PREV_W-1:0] Q_TWO   = {2'b10, {FRAC_BITS{1'b0}}};
  localparam logic [CFG_W-1:0]  NP_INIT = CFG_W'(1);

  typedef struct packed {
    logic [COUNT_WIDTH-1:0] true_positives;
    logic [COUNT_WIDTH-1:0] false_positives;
    logic                   last_row;
  } in_data_t;

  typedef struct packed {
    logic [AREA_W-1:0] area_so_far;
    logic              final_value;
  } out_data_t;

  typedef struct packed {
    logic                   start;
    logic [COUNT_WIDTH-1:0] num;
    logic [DEN_W-1:0]       den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [AREA_W-1:0] quo;
  } div_stat_t;

  // area plus product scaled down by one, saturated at one
  function automatic logic [AREA_W-1:0] sat_add(input logic [AREA_W-1:0] acc,
                                                input logic [PROD_W-1:0] prod);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(acc) + SUM_W'(prod[PROD_W-1:FRAC_BITS]);
    return (sum > SUM_W'(Q_ONE)) ? Q_ONE : sum[AREA_W-1:0];
  endfunction

endpackage

/* sv/apa_div_unit.sv */
// restoring fraction divider, one quotient bit per cycle, clamped to one
module apa_div_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  apa_pkg::div_req_t  req,
  output apa_pkg::div_stat_t stat
);
  import apa_pkg::*;

  logic [DEN_W-1:0]     rem_r;
  logic [DEN_W-1:0]     rem_nxt;
  logic [DEN_W-1:0]     den_r;
  logic [FRAC_BITS-1:0] quo_r;
  logic [CNT_W-1:0]     cnt_r;
  logic                 sat_r;
  logic                 done_r;
  logic [DEN_W:0]       shifted;
  logic                 ge;

  always_comb begin
    shifted = {rem_r, 1'b0};
    ge      = shifted >= {1'b0, den_r};
    rem_nxt = ge ? DEN_W'(shifted - {1'b0, den_r}) : shifted[DEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else if (req.start) begin
      cnt_r  <= CNT_W'(FRAC_BITS);
      done_r <= 1'b0;
    end else if (cnt_r != '0) begin
      cnt_r  <= cnt_r - CNT_W'(1);
      done_r <= (cnt_r == CNT_W'(1));
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= {1'b0, req.num};
      den_r <= req.den;
      quo_r <= '0;
      // zero divisor or quotient of one or more
      sat_r <= (req.den == '0) || ({1'b0, req.num} >= req.den);
    end else if (cnt_r != '0) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[FRAC_BITS-2:0], ge};
    end
  end

  assign stat.done = done_r;
  assign stat.quo  = sat_r ? Q_ONE : {1'b0, quo_r};

  a_done_after_count: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(cnt_r) == CNT_W'(1))
    else $error("divider done without finishing its count");
  a_quo_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> stat.quo <= Q_ONE)
    else $error("divider quotient above one");
  a_start_loads: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |=> cnt_r == CNT_W'(FRAC_BITS) && !done_r)
    else $error("divider start did not load the count");

endmodule

/* sv/average_precision_accumulator_core.sv */
// top level: interpolated average precision accumulator over threshold rows
// a row is accepted only in the idle state, so a new row waits until the previous result is taken
// each row runs the shared restoring divider once for recall and once for precision
// reset: synchronous active low; num_positive returns to 1, area and best precision to 0,
//   previous recall to 2.0; a final row also returns the accumulator state to these values
module average_precision_accumulator_core (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  apa_pkg::in_data_t         in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output apa_pkg::out_data_t        out_data,
  input  logic                      cfg_we,
  input  logic [apa_pkg::CFG_W-1:0] cfg_data
);
  import apa_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RDIV = 4'd1;
  localparam logic [3:0] S_MUL1 = 4'd2;
  localparam logic [3:0] S_ACC1 = 4'd3;
  localparam logic [3:0] S_PDIV = 4'd4;
  localparam logic [3:0] S_MUL2 = 4'd5;
  localparam logic [3:0] S_ACC2 = 4'd6;
  localparam logic [3:0] S_OUT  = 4'd7;

  logic [3:0]             state_r;
  logic [3:0]             state_nxt;
  logic [CFG_W-1:0]       np_r;
  logic [COUNT_WIDTH-1:0] tp_r;
  logic [COUNT_WIDTH-1:0] fp_r;
  logic                   last_r;
  logic [AREA_W-1:0]      recall_r;
  logic [PREV_W-1:0]      prev_r;
  logic [AREA_W-1:0]      best_r;
  logic [AREA_W-1:0]      area_r;
  logic [PROD_W-1:0]      prod_r;
  out_data_t              out_data_r;

  logic                   in_accept;
  logic                   out_accept;
  logic [PREV_W-1:0]      mul_b;
  logic [PROD_W-1:0]      prod_nxt;
  logic [AREA_W-1:0]      area_sum;
  div_req_t               div_req;
  div_stat_t              div_stat;

  assign in_stall   = (state_r != S_IDLE);
  assign in_accept  = in_valid && !in_stall;
  assign out_valid  = (state_r == S_OUT);
  assign out_accept = out_valid && !out_stall;
  assign out_data   = out_data_r;

  // divider requests: recall at accept, precision together with the first area update
  always_comb begin
    div_req.start = in_accept || (state_r == S_ACC1);
    if (state_r == S_ACC1) begin
      div_req.num = tp_r;
      div_req.den = {1'b0, tp_r} + {1'b0, fp_r};
    end else begin
      div_req.num = in_data.true_positives;
      div_req.den = DEN_W'(np_r[NP_W-1:0]);
    end
  end

  apa_div_unit u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .stat (div_stat)
  );

  // shared multiplier operand: recall drop, or final recall on the tail term
  always_comb begin
    if (state_r == S_MUL1) begin
      mul_b = ({1'b0, recall_r} < prev_r) ? (prev_r - {1'b0, recall_r}) : '0;
    end else begin
      mul_b = last_r ? {1'b0, recall_r} : '0;
    end
    prod_nxt = PROD_W'(best_r) * PROD_W'(mul_b);
    area_sum = sat_add(area_r, prod_r);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_accept) state_nxt = S_RDIV;
      S_RDIV: if (div_stat.done) state_nxt = S_MUL1;
      S_MUL1: state_nxt = S_ACC1;
      S_ACC1: state_nxt = S_PDIV;
      S_PDIV: if (div_stat.done) state_nxt = S_MUL2;
      S_MUL2: state_nxt = S_ACC2;
      S_ACC2: state_nxt = S_OUT;
      S_OUT:  if (out_accept) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      np_r    <= NP_INIT;
      best_r  <= '0;
      prev_r  <= Q_TWO;
      area_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        np_r <= cfg_data;
      end
      case (state_r)
        S_MUL1: prev_r <= {1'b0, recall_r};
        S_ACC1: area_r <= area_sum;
        S_PDIV: begin
          // empty row leaves best precision alone
          if (div_stat.done && (tp_r != '0 || fp_r != '0) && div_stat.quo > best_r) begin
            best_r <= div_stat.quo;
          end
        end
        S_ACC2: begin
          if (last_r) begin
            best_r <= '0;
            prev_r <= Q_TWO;
            area_r <= '0;
          end else begin
            area_r <= area_sum;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      tp_r   <= in_data.true_positives;
      fp_r   <= in_data.false_positives;
      last_r <= in_data.last_row;
    end
    if (state_r == S_RDIV && div_stat.done) begin
      recall_r <= div_stat.quo;
    end
    if (state_r == S_MUL1 || state_r == S_MUL2) begin
      prod_r <= prod_nxt;
    end
    if (state_r == S_ACC2) begin
      out_data_r.area_so_far <= area_sum;
      out_data_r.final_value <= last_r;
    end
  end

  a_accept_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> state_r == S_RDIV)
    else $error("accepted request did not start the recall division");
  a_area_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    area_r <= Q_ONE && best_r <= Q_ONE)
    else $error("area or best precision above one");
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_accept |=> !out_valid)
    else $error("result presented twice");
  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> (state_r == S_RDIV || state_r == S_PDIV))
    else $error("divider finished outside a division step");
  a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ACC2 && last_r) |=> area_r == '0 && prev_r == Q_TWO)
    else $error("final row did not clear the accumulator");

endmodule
